// ===== sv/fls_pkg.sv =====
// Shared definitions for the double-precision radix sorter.
// Key width, default sizes, sequencer states and the order-key mapping.
// No dependencies.
`default_nettype none

package fls_pkg;

  localparam int KEY_W          = 64;
  localparam int MAX_KEYS_DEF   = 64;
  localparam int DIGIT_BITS_DEF = 8;

  localparam logic [KEY_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_OUT_RD,
    ST_OUT_HOLD
  } fls_state_e;

  function automatic logic [KEY_W-1:0] to_order(input logic [KEY_W-1:0] x);
    return x[KEY_W-1] ? (x ^ ALL_ONES) : (x ^ SIGN_BIT);
  endfunction

  function automatic logic [KEY_W-1:0] from_order(input logic [KEY_W-1:0] x);
    return x[KEY_W-1] ? (x ^ SIGN_BIT) : (x ^ ALL_ONES);
  endfunction

endpackage

`default_nettype wire

// ===== sv/fls_key_if.sv =====
// Input channel of the sorter: one key word per handshake.
// Depends on fls_pkg for the key width.
`default_nettype none

interface fls_key_if import fls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_bits;
  logic             last_key;

  modport source (output valid, key_bits, last_key, input ready);
  modport sink   (input valid, key_bits, last_key, output ready);
endinterface

`default_nettype wire

// ===== sv/fls_sorted_if.sv =====
// Output channel of the sorter: one sorted key word per handshake.
// Depends on fls_pkg for the key width.
`default_nettype none

interface fls_sorted_if import fls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_bits;
  logic             last_sorted;

  modport source (output valid, sorted_bits, last_sorted, input ready);
  modport sink   (input valid, sorted_bits, last_sorted, output ready);
endinterface

`default_nettype wire

// ===== sv/float64_lsd_radix_sort.sv =====
// Load: one key per cycle while ready; the batch closes on last_key or at MAX_KEYS keys.
// Sort: each digit pass clears the bucket counts, counts the digits, turns counts into bucket
// start positions and scatters the keys, using the one-read, one-write bucket-count memory.
// Output: after a read state, one key per cycle while ready; then the next batch loads.
// Reset (asynchronous, active low) returns to loading an empty batch; stores keep contents.
`default_nettype none

module float64_lsd_radix_sort import fls_pkg::*; #(
  parameter int MAX_KEYS   = MAX_KEYS_DEF,
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  fls_key_if.sink       key_i,
  fls_sorted_if.source  sorted_o
);

  localparam int IW     = $clog2(MAX_KEYS);
  localparam int CW     = $clog2(MAX_KEYS + 1);
  localparam int KAW    = IW + 1;
  localparam int NB     = 2 ** DIGIT_BITS;
  localparam int JW     = DIGIT_BITS + 1;
  localparam int PASSES = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PW     = $clog2(PASSES);
  localparam int SW     = $clog2(KEY_W);
  localparam logic FINAL_BANK = 1'(PASSES % 2);

  logic [KEY_W-1:0] key_mem [2**KAW];
  logic [CW-1:0]    cnt_mem [NB];

  fls_state_e state_q, state_d;
  logic [CW-1:0]         idx_q, idx_d, n_q, n_d, run_q, run_d;
  logic [JW-1:0]         j_q, j_d;
  logic [PW-1:0]         pass_q, pass_d;
  logic                  kv_q, kv_d, cv_q, cv_d, pv_q, pv_d;
  logic [KEY_W-1:0]      s2_key_q, s2_key_d;
  logic                  fw_v_q;
  logic [DIGIT_BITS-1:0] fw_a_q;
  logic [CW-1:0]         fw_d_q;

  logic                  key_we;
  logic [KAW-1:0]        key_wa, key_ra;
  logic [KEY_W-1:0]      key_wd, key_rd_q;
  logic                  cnt_we;
  logic [DIGIT_BITS-1:0] cnt_wa, cnt_ra, cnt_ra_q;
  logic [CW-1:0]         cnt_wd, cnt_rd_q;

  logic [SW-1:0]         shift;
  logic [DIGIT_BITS-1:0] digit;
  logic [CW-1:0]         cval;
  logic                  src_bank;
  logic                  out_last;
  logic                  in_ready, out_valid;

  assign shift    = SW'(pass_q * DIGIT_BITS);
  assign digit    = DIGIT_BITS'(key_rd_q >> shift);
  assign cval     = (fw_v_q && (fw_a_q == cnt_ra_q)) ? fw_d_q : cnt_rd_q;
  assign src_bank = pass_q[0];
  assign out_last = ((idx_q + CW'(1)) == n_q);

  assign key_i.ready          = in_ready;
  assign sorted_o.valid       = out_valid;
  assign sorted_o.sorted_bits = from_order(key_rd_q);
  assign sorted_o.last_sorted = out_last;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
    cnt_ra_q <= cnt_ra;
  end

  always_ff @(posedge clk_i) begin
    s2_key_q <= s2_key_d;
    if (cnt_we) begin
      fw_a_q <= cnt_wa;
      fw_d_q <= cnt_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      idx_q   <= '0;
      n_q     <= '0;
      run_q   <= '0;
      j_q     <= '0;
      pass_q  <= '0;
      kv_q    <= 1'b0;
      cv_q    <= 1'b0;
      pv_q    <= 1'b0;
      fw_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      run_q   <= run_d;
      j_q     <= j_d;
      pass_q  <= pass_d;
      kv_q    <= kv_d;
      cv_q    <= cv_d;
      pv_q    <= pv_d;
      if (cnt_we) begin
        fw_v_q <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    n_d       = n_q;
    run_d     = run_q;
    j_d       = j_q;
    pass_d    = pass_q;
    kv_d      = 1'b0;
    cv_d      = 1'b0;
    pv_d      = 1'b0;
    s2_key_d  = s2_key_q;
    key_we    = 1'b0;
    key_wa    = '0;
    key_wd    = '0;
    key_ra    = '0;
    cnt_we    = 1'b0;
    cnt_wa    = '0;
    cnt_wd    = '0;
    cnt_ra    = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (key_i.valid) begin
          key_we = 1'b1;
          key_wa = {1'b0, idx_q[IW-1:0]};
          key_wd = to_order(key_i.key_bits);
          idx_d  = idx_q + CW'(1);
          if (key_i.last_key || (idx_q == CW'(MAX_KEYS - 1))) begin
            n_d     = idx_q + CW'(1);
            idx_d   = '0;
            j_d     = '0;
            pass_d  = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = j_q[DIGIT_BITS-1:0];
        cnt_wd = '0;
        j_d    = j_q + JW'(1);
        if (j_q == JW'(NB - 1)) begin
          j_d     = '0;
          idx_d   = '0;
          state_d = ST_COUNT;
        end
      end
      ST_COUNT, ST_SCATTER: begin
        // issue key read, then bucket read, then bucket update and, in scatter, key write
        if (idx_q < n_q) begin
          key_ra = {src_bank, idx_q[IW-1:0]};
          kv_d   = 1'b1;
          idx_d  = idx_q + CW'(1);
        end
        if (kv_q) begin
          cnt_ra   = digit;
          cv_d     = 1'b1;
          s2_key_d = key_rd_q;
        end
        if (cv_q) begin
          cnt_we = 1'b1;
          cnt_wa = cnt_ra_q;
          cnt_wd = cval + CW'(1);
          if (state_q == ST_SCATTER) begin
            key_we = 1'b1;
            key_wa = {~src_bank, cval[IW-1:0]};
            key_wd = s2_key_q;
          end
        end
        if ((idx_q == n_q) && !kv_q && !cv_q) begin
          if (state_q == ST_COUNT) begin
            j_d     = '0;
            run_d   = '0;
            state_d = ST_PREFIX;
          end else if (pass_q == PW'(PASSES - 1)) begin
            idx_d   = '0;
            state_d = ST_OUT_RD;
          end else begin
            pass_d  = pass_q + PW'(1);
            j_d     = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      ST_PREFIX: begin
        // turn counts into bucket start positions
        if (j_q < JW'(NB)) begin
          cnt_ra = j_q[DIGIT_BITS-1:0];
          pv_d   = 1'b1;
          j_d    = j_q + JW'(1);
        end
        if (pv_q) begin
          cnt_we = 1'b1;
          cnt_wa = cnt_ra_q;
          cnt_wd = run_q;
          run_d  = run_q + cval;
        end
        if ((j_q == JW'(NB)) && !pv_q) begin
          idx_d   = '0;
          state_d = ST_SCATTER;
        end
      end
      ST_OUT_RD: begin
        key_ra  = {FINAL_BANK, idx_q[IW-1:0]};
        state_d = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        out_valid = 1'b1;
        if (sorted_o.ready) begin
          if (out_last) begin
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
        key_ra = {FINAL_BANK, idx_d[IW-1:0]};
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/fls_checker.sv =====
// Port-level checks for the radix sorter, bound to its top level.
// Watches only the handshake and last-word signals of the two channels.
`default_nettype none

module fls_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_last_i
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  a_load_or_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while output valid");

  a_close_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> !in_ready_i && !out_valid_i)
    else $error("batch not closed after last key");

  a_end_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_i) |=> !out_valid_i && in_ready_i)
    else $error("no return to loading after last sorted word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

endmodule

bind float64_lsd_radix_sort fls_checker u_fls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (key_i.valid),
  .in_ready_i  (key_i.ready),
  .in_last_i   (key_i.last_key),
  .out_valid_i (sorted_o.valid),
  .out_ready_i (sorted_o.ready),
  .out_last_i  (sorted_o.last_sorted)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for float64_lsd_radix_sort: drives key words and checks sorted words.
// A scoreboard orders each closed batch by the total order of double bit patterns and compares every output word.
// Depends on fls_pkg, fls_key_if, fls_sorted_if and the sorter RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fls_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 110;
  localparam int NUM_SPECIAL  = 17;

  localparam logic [KEY_W-1:0] SPECIAL_KEYS [NUM_SPECIAL] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
    64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000, 64'hfff8_0000_0000_0000,
    64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0001, 64'h7fef_ffff_ffff_ffff, 64'hffef_ffff_ffff_ffff,
    64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000, 64'h0010_0000_0000_0000,
    64'h3ff0_0000_0000_0001, 64'h3ff0_0000_0000_0000
  };

  class key_order_board;
    typedef struct packed {
      logic [KEY_W-1:0] bits;
      logic             last;
    } sorted_word_t;

    logic [KEY_W-1:0] open_batch[$];
    sorted_word_t     expected_sorted[$];
    int               errors;
    int               batches;
    int               words_checked;

    static function logic [KEY_W-1:0] order_key(logic [KEY_W-1:0] x);
      return x[KEY_W-1] ? ~x : {1'b1, x[KEY_W-2:0]};
    endfunction

    function void close_batch();
      logic [KEY_W-1:0] ordered[$];
      logic [KEY_W-1:0] k;
      sorted_word_t     w;
      int               j;
      ordered = open_batch;
      for (int i = 1; i < ordered.size(); i++) begin
        k = ordered[i];
        j = i;
        while (j > 0 && order_key(ordered[j-1]) > order_key(k)) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = k;
      end
      foreach (ordered[i]) begin
        w.bits = ordered[i];
        w.last = (i == ordered.size() - 1);
        expected_sorted.push_back(w);
      end
      open_batch.delete();
      batches++;
    endfunction

    function void note_key(logic [KEY_W-1:0] bits, logic last);
      open_batch.push_back(bits);
      if (last || open_batch.size() == MAX_KEYS_DEF) close_batch();
    endfunction

    function void check_sorted(logic [KEY_W-1:0] bits, logic last);
      sorted_word_t w;
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected sorted word %h last %b", $time, bits, last);
        errors++;
        return;
      end
      w = expected_sorted.pop_front();
      words_checked++;
      if (bits !== w.bits) begin
        $display("%0t: sorted_bits expected %h actual %h", $time, w.bits, bits);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last_sorted expected %b actual %b", $time, w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_sorted.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_ready = 1'b0;
  logic rx_steady;
  int   cycle_count = 0;
  int   keys_sent = 0;
  int   stall_left = 0;

  logic [KEY_W-1:0] batch_keys[$];
  key_order_board   board = new();

  fls_key_if    key_ch ();
  fls_sorted_if sorted_ch ();

  assign sorted_ch.ready = rx_ready;

  float64_lsd_radix_sort dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_ch),
    .sorted_o (sorted_ch)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else if (rx_steady) begin
      rx_ready <= 1'b1;
    end else if (stall_left > 0) begin
      rx_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 60) begin
      rx_ready <= 1'b1;
    end else begin
      rx_ready <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sorted_ch.valid && sorted_ch.ready)
      board.check_sorted(sorted_ch.sorted_bits, sorted_ch.last_sorted);
  end

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               mode;
    int               sz;
    mode = $urandom_range(0, 9);
    sz   = batch_keys.size();
    k    = {$urandom, $urandom};
    case (mode)
      4: k = SPECIAL_KEYS[$urandom_range(0, NUM_SPECIAL - 1)];
      5: if (sz > 0) k = batch_keys[$urandom_range(0, sz - 1)];
      6, 7: if (sz > 0) begin
        k = batch_keys[$urandom_range(0, sz - 1)];
        k[8*$urandom_range(0, 7) +: 8] = 8'($urandom);
      end
      8: k[62:52] = 11'($urandom_range(1021, 1026));
      9: if (sz > 0) k = batch_keys[$urandom_range(0, sz - 1)] ^ SIGN_BIT;
      default: ;
    endcase
    batch_keys.push_back(k);
    return k;
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] bits, input logic last, input int gap);
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_bits <= bits;
    key_ch.last_key <= last;
    do @(posedge clk_i); while (!key_ch.ready);
    board.note_key(bits, last);
    keys_sent++;
  endtask

  task automatic send_batch(input int count, input logic close_on_last);
    batch_keys.delete();
    for (int i = 0; i < count; i++)
      send_key(pick_key(), close_on_last && (i == count - 1), pick_gap());
  endtask

  task automatic drain_sorted();
    key_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int n;
    int random_sent;
    int batch_idx;
    rst_ni          <= 1'b0;
    rx_steady       <= 1'b1;
    key_ch.valid    <= 1'b0;
    key_ch.key_bits <= '0;
    key_ch.last_key <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_key(64'h3ff0_0000_0000_0000, 1'b1, 0);
    for (int i = 0; i < NUM_SPECIAL; i++)
      send_key(SPECIAL_KEYS[i], i == NUM_SPECIAL - 1, 0);
    send_key(64'h4000_0000_0000_0000, 1'b0, 0);
    send_key(64'h3ff0_0000_0000_0000, 1'b1, 0);
    drain_sorted();

    rx_steady <= 1'b0;
    send_batch(MAX_KEYS_DEF, 1'b0);
    random_sent = MAX_KEYS_DEF;
    batch_idx   = 0;
    while (random_sent < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      rx_steady <= ($urandom_range(0, 3) == 0);
      send_batch(n, 1'b1);
      random_sent += n;
      batch_idx++;
      if (batch_idx == 5) drain_sorted();
    end

    drain_sorted();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d keys in %0d batches, %0d sorted words checked,", keys_sent,
             board.batches, board.words_checked);
    $display("with NaNs, infinities, signed zeros, duplicates and a batch closed by size.");
    if (board.errors == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ===== float64_lsd_radix_sort.f =====
sv/fls_pkg.sv
sv/fls_key_if.sv
sv/fls_sorted_if.sv
sv/float64_lsd_radix_sort.sv
sv/fls_checker.sv
test/tb_top.sv
